// ===== sv/hypercube_transition_rate_core_assert.svh =====
// Assertion macros shared by the RTL of the transition rate core.
`ifndef HYPERCUBE_TRANSITION_RATE_CORE_ASSERT_SVH
`define HYPERCUBE_TRANSITION_RATE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcr: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcr: next-cycle check failed");

`endif

// ===== sv/hcr_pkg.sv =====
`default_nettype none

package hcr_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_FEATURES_DEF = 8;
    localparam int WEIGHT_DEPTH_DEF = 4096;

    // Field widths.
    localparam int OP_W    = 1;
    localparam int IDX_W   = 12;
    localparam int W_W     = 24;
    localparam int STATE_W = 8;
    localparam int RATE_W  = 32;

    // Configuration registers.
    localparam int ORD_W      = 3;
    localparam int FCW        = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURES = 1'b1;

    localparam logic [ORD_W-1:0] ORD_RESET  = 3'd1;
    localparam logic [FCW-1:0]   FC_RESET   = 4'd8;

    // Interaction orders.
    localparam logic [ORD_W-1:0] ORD_SINGLE = 3'd1;
    localparam logic [ORD_W-1:0] ORD_PAIR   = 3'd2;
    localparam logic [ORD_W-1:0] ORD_TRIPLE = 3'd3;
    localparam logic [ORD_W-1:0] ORD_QUAD   = 3'd4;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
    localparam logic [OP_W-1:0] OP_EVAL  = 1'b1;

    // Exponential constants.
    localparam logic [31:0] LOG2E_Q30   = 32'h5C55_1D95;
    localparam logic [31:0] LN2_Q32     = 32'hB172_17F8;
    localparam int          EXP_LIMIT   = 12 * 65536;
    localparam int          EXP_SOFF_W  = 21;
    localparam logic [63:0] EXP_OFFSET  = (64'd1 << 51) - (64'd786432 * 64'h5C55_1D95);
    localparam logic [5:0]  EXP_K_UNITY = 6'd48;
    localparam logic [3:0]  TAYLOR_FIRST = 4'd2;
    localparam logic [3:0]  TAYLOR_LAST  = 4'd11;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PREP,
        S_COEF,
        S_SELF,
        S_WALK,
        S_DRAIN,
        S_RANGE,
        S_EXP_K,
        S_EXP_G,
        S_EXP_M,
        S_T1,
        S_T2,
        S_T3,
        S_SHIFT,
        S_LOAD
    } t_state;

    // floor(2^32 / n) for the Taylor divisors.
    function automatic logic [31:0] recip(input logic [3:0] n);
        logic [31:0] r;
        case (n)
            4'd2:    r = 32'h8000_0000;
            4'd3:    r = 32'h5555_5555;
            4'd4:    r = 32'h4000_0000;
            4'd5:    r = 32'h3333_3333;
            4'd6:    r = 32'h2AAA_AAAA;
            4'd7:    r = 32'h2492_4924;
            4'd8:    r = 32'h2000_0000;
            4'd9:    r = 32'h1C71_C71C;
            4'd10:   r = 32'h1999_9999;
            4'd11:   r = 32'h1745_D174;
            default: r = 32'h0000_0000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/hcr_in_if.sv =====
`default_nettype none

interface hcr_in_if;
    logic                               valid;
    logic                               ready;
    logic [hcr_pkg::OP_W-1:0]           op;
    logic [hcr_pkg::IDX_W-1:0]          weight_index;
    logic signed [hcr_pkg::W_W-1:0]     weight_value;
    logic [hcr_pkg::STATE_W-1:0]        from_state;
    logic [hcr_pkg::STATE_W-1:0]        to_state;

    modport source (
        output valid, op, weight_index, weight_value, from_state, to_state,
        input  ready
    );
    modport sink (
        input  valid, op, weight_index, weight_value, from_state, to_state,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/hcr_out_if.sv =====
`default_nettype none

interface hcr_out_if;
    logic                           valid;
    logic                           ready;
    logic [hcr_pkg::RATE_W-1:0]     rate_value;
    logic                           not_neighbours;
    logic                           saturated;

    modport source (
        output valid, rate_value, not_neighbours, saturated,
        input  ready
    );
    modport sink (
        input  valid, rate_value, not_neighbours, saturated,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/hypercube_transition_rate_core.sv =====
// A weight write goes into the memory at its transfer. An evaluation of non-neighbours goes
// straight to the result stage; an evaluation of neighbours first walks W index tuples,
// where W is 0, L, L(L+1)/2 or L(L+1)(L+2)/6 for order 1 to 4, then runs the exponential.
// Throughput: one evaluation at a time, set by the one-read-per-cycle weight memory walk
// and the shared 32x32 multiplier of the exponential.
// Reset is synchronous, active low; the weight memory is not cleared.
`default_nettype none

`include "hypercube_transition_rate_core_assert.svh"

module hypercube_transition_rate_core #(
    parameter int MAX_FEATURES = hcr_pkg::MAX_FEATURES_DEF,
    parameter int WEIGHT_DEPTH = hcr_pkg::WEIGHT_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    hcr_in_if.sink                              i_in,
    hcr_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [hcr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hcr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // Width of a feature index, of a full table address and of the memory address.
    localparam int FW   = $clog2(MAX_FEATURES);
    localparam int FAW  = $clog2(MAX_FEATURES ** 4);
    localparam int MAW  = $clog2(WEIGHT_DEPTH);
    localparam int CW0  = (FAW > MAW) ? FAW : MAW;
    // Compare width: wide enough for any address and for the depth itself.
    localparam int CW   = ((CW0 > hcr_pkg::IDX_W) ? CW0 : hcr_pkg::IDX_W) + 1;
    // The accumulator holds at most MAX_FEATURES^4 weights of 24 bits.
    localparam int ACW  = FAW + hcr_pkg::W_W + 1;
    localparam int MAXW = (MAX_FEATURES > hcr_pkg::STATE_W) ? MAX_FEATURES : hcr_pkg::STATE_W;
    localparam int FCW  = hcr_pkg::FCW;
    localparam int ORW  = hcr_pkg::ORD_W;

    localparam logic signed [ACW-1:0] LIM     = ACW'(hcr_pkg::EXP_LIMIT);
    localparam logic signed [ACW-1:0] NEG_LIM = -LIM;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ORW-1:0] r_order;
    logic [FCW-1:0] r_fcount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order  <= hcr_pkg::ORD_RESET;
            r_fcount <= hcr_pkg::FC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hcr_pkg::CFG_ORDER:    r_order  <= i_cfg_data[ORW-1:0];
                hcr_pkg::CFG_FEATURES: r_fcount <= i_cfg_data[FCW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Out-of-range register values are clamped into their legal range.
    logic [FCW-1:0] nf_c;
    logic [ORW-1:0] ord_c;

    always_comb begin
        if (r_fcount == '0) begin
            nf_c = FCW'(1);
        end else if (r_fcount > FCW'(MAX_FEATURES)) begin
            nf_c = FCW'(MAX_FEATURES);
        end else begin
            nf_c = r_fcount;
        end
        if (r_order < hcr_pkg::ORD_SINGLE) begin
            ord_c = hcr_pkg::ORD_SINGLE;
        end else if (r_order > hcr_pkg::ORD_QUAD) begin
            ord_c = hcr_pkg::ORD_QUAD;
        end else begin
            ord_c = r_order;
        end
    end

    // ------------------------------------------------------------------
    // State decode at the input transfer
    // ------------------------------------------------------------------
    // Feature k sits in bit L-1-k of a state. Reversing the used bits over the full
    // feature width and shifting down by MAX_FEATURES-L puts feature k at bit k, so
    // that the walk can index the source features directly.
    logic [MAXW-1:0]         from_w, to_w;
    logic [MAX_FEATURES-1:0] fmask, fm, tm, diff, rev_f, rev_d, dvec_c, dloc;
    logic [FCW-1:0]          shamt;
    logic [FW-1:0]           locus_c;
    logic                    neighbour_c;

    always_comb begin
        from_w = MAXW'(i_in.from_state);
        to_w   = MAXW'(i_in.to_state);
        fmask  = ~({MAX_FEATURES{1'b1}} << nf_c);
        fm     = from_w[MAX_FEATURES-1:0] & fmask;
        tm     = to_w[MAX_FEATURES-1:0] & fmask;
        diff   = fm ^ tm;
        for (int k = 0; k < MAX_FEATURES; k++) begin
            rev_f[k] = fm[MAX_FEATURES-1-k];
            rev_d[k] = diff[MAX_FEATURES-1-k];
        end
        shamt  = FCW'(MAX_FEATURES) - nf_c;
        dvec_c = rev_f >> shamt;
        dloc   = rev_d >> shamt;
        // Neighbours differ in exactly one feature.
        neighbour_c = (diff != '0) && ((diff & (diff - MAX_FEATURES'(1))) == '0);
        locus_c = '0;
        for (int k = 0; k < MAX_FEATURES; k++) begin
            if (dloc[k]) begin
                locus_c = FW'(k);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------
    hcr_pkg::t_state r_state, n_state;

    logic [FCW-1:0]          r_nf;
    logic [ORW-1:0]          r_ord;
    logic [MAX_FEATURES-1:0] r_dvec;
    logic [FW-1:0]           r_locus;
    logic [2*FCW-1:0]        r_sq;
    logic [FAW-1:0]          r_c1, r_c2, r_c3;
    logic [FW-1:0]           r_x, r_y, r_z, n_x, n_y, n_z;

    // Weight read pipeline: issue, memory read, accumulate.
    logic                    r_a_vld, r_a_use, r_b_vld, r_b_use;
    logic [MAW-1:0]          r_a_addr;
    logic [hcr_pkg::W_W-1:0] r_rd_data;
    logic signed [ACW-1:0]   r_acc;

    // Exponential datapath.
    logic [63:0]             r_prod;
    logic [5:0]              r_k;
    logic [31:0]             r_f, r_g, r_term, r_p;
    logic [33:0]             r_m;
    logic [3:0]              r_n;

    // Result waiting for the output register, and the output register itself.
    logic [hcr_pkg::RATE_W-1:0] r_res_rate, r_out_rate;
    logic                       r_res_nn, r_res_sat, r_out_nn, r_out_sat, r_out_valid;

    logic [hcr_pkg::W_W-1:0] mem_weight [WEIGHT_DEPTH];

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic in_acc, in_eval, in_write, out_load;
    logic [CW-1:0] wr_idx_w;

    assign i_in.ready = (r_state == hcr_pkg::S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign in_eval    = in_acc && (i_in.op == hcr_pkg::OP_EVAL);
    assign wr_idx_w   = CW'(i_in.weight_index);
    // Writes beyond the table are dropped.
    assign in_write   = in_acc && (i_in.op == hcr_pkg::OP_WRITE)
                        && (wr_idx_w < CW'(WEIGHT_DEPTH));
    // A finished result moves to the output register once that is free or being emptied.
    assign out_load   = (r_state == hcr_pkg::S_LOAD) && (!r_out_valid || o_out.ready);

    assign o_out.valid          = r_out_valid;
    assign o_out.rate_value     = r_out_rate;
    assign o_out.not_neighbours = r_out_nn;
    assign o_out.saturated      = r_out_sat;

    // ------------------------------------------------------------------
    // Address generation for the weight walk
    // ------------------------------------------------------------------
    // The address is x*c3 + y*c2 + z*c1 + locus. The coefficients are L^3, L^2 and L
    // where the order uses that digit and zero otherwise, so one loop nest over
    // x <= y <= z serves every order: the unused outer digits stay pinned at zero.
    // With x = y = z = locus the same expression gives the locus self-weight.
    logic [CW-1:0]  addr_w;
    logic           addr_in_rng;
    logic [FCW-1:0] nfm1_full;
    logic [FW-1:0]  nfm1, xmax, ymax;
    logic           use_walk, walk_last;

    always_comb begin
        addr_w = CW'(r_x) * CW'(r_c3) + CW'(r_y) * CW'(r_c2)
                 + CW'(r_z) * CW'(r_c1) + CW'(r_locus);
        // Addresses beyond the table are never accumulated, so they simply add nothing.
        addr_in_rng = addr_w < CW'(WEIGHT_DEPTH);
        nfm1_full   = r_nf - FCW'(1);
        nfm1        = nfm1_full[FW-1:0];
        xmax        = (r_ord == hcr_pkg::ORD_QUAD) ? nfm1 : '0;
        ymax        = (r_ord >= hcr_pkg::ORD_TRIPLE) ? nfm1 : '0;
        // A term counts only when every source feature it names is set.
        use_walk    = ((r_ord != hcr_pkg::ORD_QUAD) || r_dvec[r_x])
                      && ((r_ord < hcr_pkg::ORD_TRIPLE) || r_dvec[r_y])
                      && r_dvec[r_z];
        walk_last   = (r_z == nfm1) && (r_y == ymax) && (r_x == xmax);
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        if (r_z != nfm1) begin
            n_z = r_z + FW'(1);
        end else if (r_y != ymax) begin
            n_y = r_y + FW'(1);
            n_z = r_y + FW'(1);
        end else if (r_x != xmax) begin
            n_x = r_x + FW'(1);
            n_y = r_x + FW'(1);
            n_z = r_x + FW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Exponential helpers
    // ------------------------------------------------------------------
    // The sum is taken to base 2: t = sum * log2(e). Adding an offset makes t positive,
    // its integer part k sets the final shift and its fraction f gives g = f * ln 2.
    // exp(g) comes from a Taylor series up to the term in g^11; each term divides by n through a
    // multiply by floor(2^32/n) and a single correction step.
    logic signed [ACW-1:0] s_off;
    logic [63:0]           tb;
    logic [31:0]           mul_a, mul_b, q0, q_fix;
    logic [35:0]           qn, rem;
    logic                  q_corr;
    logic [5:0]            sh;
    logic [63:0]           round_inc, r64;
    logic                  exp_sat;

    always_comb begin
        s_off  = r_acc + LIM;
        tb     = r_prod + hcr_pkg::EXP_OFFSET;
        q0     = r_prod[63:32];
        qn     = {4'b0, q0} * {32'b0, r_n};
        rem    = {4'b0, r_p} - qn;
        q_corr = rem >= {32'b0, r_n};
        q_fix  = q0 + {31'b0, q_corr};

        sh        = hcr_pkg::EXP_K_UNITY - r_k;
        round_inc = 64'd1 << (sh - 6'd1);
        if (r_k >= hcr_pkg::EXP_K_UNITY) begin
            r64 = {30'b0, r_m} << (r_k - hcr_pkg::EXP_K_UNITY);
        end else begin
            r64 = ({30'b0, r_m} + round_inc) >> sh;
        end
        exp_sat = r64[63:32] != '0;

        // One shared multiplier, its operands chosen by the sequencer state.
        case (r_state)
            hcr_pkg::S_RANGE: begin
                mul_a = 32'(s_off[hcr_pkg::EXP_SOFF_W-1:0]);
                mul_b = hcr_pkg::LOG2E_Q30;
            end
            hcr_pkg::S_EXP_G: begin
                mul_a = r_f;
                mul_b = hcr_pkg::LN2_Q32;
            end
            hcr_pkg::S_T1: begin
                mul_a = r_term;
                mul_b = r_g;
            end
            hcr_pkg::S_T2: begin
                mul_a = r_prod[63:32];
                mul_b = hcr_pkg::recip(r_n);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            hcr_pkg::S_IDLE: begin
                if (in_eval) begin
                    n_state = neighbour_c ? hcr_pkg::S_PREP : hcr_pkg::S_LOAD;
                end
            end
            hcr_pkg::S_PREP:  n_state = hcr_pkg::S_COEF;
            hcr_pkg::S_COEF:  n_state = hcr_pkg::S_SELF;
            hcr_pkg::S_SELF: begin
                n_state = (r_ord == hcr_pkg::ORD_SINGLE) ? hcr_pkg::S_DRAIN
                                                         : hcr_pkg::S_WALK;
            end
            hcr_pkg::S_WALK: begin
                if (walk_last) begin
                    n_state = hcr_pkg::S_DRAIN;
                end
            end
            hcr_pkg::S_DRAIN: begin
                if (!r_a_vld && !r_b_vld) begin
                    n_state = hcr_pkg::S_RANGE;
                end
            end
            hcr_pkg::S_RANGE: begin
                if ((r_acc > LIM) || (r_acc < NEG_LIM)) begin
                    n_state = hcr_pkg::S_LOAD;
                end else begin
                    n_state = hcr_pkg::S_EXP_K;
                end
            end
            hcr_pkg::S_EXP_K: n_state = hcr_pkg::S_EXP_G;
            hcr_pkg::S_EXP_G: n_state = hcr_pkg::S_EXP_M;
            hcr_pkg::S_EXP_M: n_state = hcr_pkg::S_T1;
            hcr_pkg::S_T1:    n_state = hcr_pkg::S_T2;
            hcr_pkg::S_T2:    n_state = hcr_pkg::S_T3;
            hcr_pkg::S_T3: begin
                n_state = (r_n == hcr_pkg::TAYLOR_LAST) ? hcr_pkg::S_SHIFT
                                                        : hcr_pkg::S_T1;
            end
            hcr_pkg::S_SHIFT: n_state = hcr_pkg::S_LOAD;
            hcr_pkg::S_LOAD: begin
                if (out_load) begin
                    n_state = hcr_pkg::S_IDLE;
                end
            end
            default: n_state = hcr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hcr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Control registers of the read pipeline and the output stage
    // ------------------------------------------------------------------
    logic issue;

    assign issue = (r_state == hcr_pkg::S_SELF) || (r_state == hcr_pkg::S_WALK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_a_vld <= issue;
            r_b_vld <= r_a_vld;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Weight memory: one write port for write items, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_write) begin
            mem_weight[wr_idx_w[MAW-1:0]] <= i_in.weight_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem_weight[r_a_addr];
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_prod <= {32'b0, mul_a} * {32'b0, mul_b};

        // Stage one of the read pipeline: the self term counts whenever its address lies in the table.
        r_a_addr <= addr_w[MAW-1:0];
        if (r_state == hcr_pkg::S_SELF) begin
            r_a_use <= addr_in_rng;
        end else begin
            r_a_use <= use_walk && addr_in_rng;
        end
        r_b_use <= r_a_use;

        if (r_state == hcr_pkg::S_COEF) begin
            r_acc <= '0;
        end else if (r_b_vld && r_b_use) begin
            r_acc <= r_acc + {{(ACW - hcr_pkg::W_W){r_rd_data[hcr_pkg::W_W-1]}}, r_rd_data};
        end

        case (r_state)
            hcr_pkg::S_IDLE: begin
                r_nf    <= nf_c;
                r_ord   <= ord_c;
                r_dvec  <= dvec_c;
                r_locus <= locus_c;
                // Non-neighbours answer at once with a zero rate.
                r_res_rate <= '0;
                r_res_nn   <= 1'b1;
                r_res_sat  <= 1'b0;
            end
            hcr_pkg::S_PREP: begin
                r_sq <= r_nf * r_nf;
            end
            hcr_pkg::S_COEF: begin
                r_c1 <= (r_ord >= hcr_pkg::ORD_PAIR)   ? FAW'(r_nf) : '0;
                r_c2 <= (r_ord >= hcr_pkg::ORD_TRIPLE) ? FAW'(r_sq) : '0;
                r_c3 <= (r_ord == hcr_pkg::ORD_QUAD)   ? FAW'(r_sq * r_nf) : '0;
                r_x  <= r_locus;
                r_y  <= r_locus;
                r_z  <= r_locus;
            end
            hcr_pkg::S_SELF: begin
                r_x <= '0;
                r_y <= '0;
                r_z <= '0;
            end
            hcr_pkg::S_WALK: begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
            end
            hcr_pkg::S_RANGE: begin
                // Sums beyond twelve saturate; sums below minus twelve give zero.
                r_res_nn   <= 1'b0;
                r_res_sat  <= r_acc > LIM;
                r_res_rate <= (r_acc > LIM) ? '1 : '0;
            end
            hcr_pkg::S_EXP_K: begin
                r_k <= tb[51:46];
                r_f <= tb[45:14];
            end
            hcr_pkg::S_EXP_M: begin
                // The first Taylor term is g itself.
                r_g    <= r_prod[63:32];
                r_term <= r_prod[63:32];
                r_m    <= 34'h1_0000_0000 + 34'(r_prod[63:32]);
                r_n    <= hcr_pkg::TAYLOR_FIRST;
            end
            hcr_pkg::S_T2: begin
                r_p <= r_prod[63:32];
            end
            hcr_pkg::S_T3: begin
                r_term <= q_fix;
                r_m    <= r_m + 34'(q_fix);
                r_n    <= r_n + 4'd1;
            end
            hcr_pkg::S_SHIFT: begin
                r_res_rate <= exp_sat ? '1 : r64[31:0];
                r_res_sat  <= exp_sat;
            end
            default: begin
            end
        endcase

        if (out_load) begin
            r_out_rate <= r_res_rate;
            r_out_nn   <= r_res_nn;
            r_out_sat  <= r_res_sat;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `HCR_ASSERT_NOW(a_issue_in_walk, i_clk, i_rst_n, r_a_vld,
        (r_state == hcr_pkg::S_WALK) || (r_state == hcr_pkg::S_DRAIN))
    `HCR_ASSERT_NOW(a_range_after_drain, i_clk, i_rst_n, r_state == hcr_pkg::S_RANGE,
        !r_a_vld && !r_b_vld)
    `HCR_ASSERT_NOW(a_walk_order, i_clk, i_rst_n, r_state == hcr_pkg::S_WALK,
        (r_x <= r_y) && (r_y <= r_z) && (FCW'(r_z) < r_nf))
    `HCR_ASSERT_NOW(a_recip_one_step, i_clk, i_rst_n, r_state == hcr_pkg::S_T3,
        rem < {31'b0, r_n, 1'b0})
    `HCR_ASSERT_NEXT(a_sum_settled, i_clk, i_rst_n,
        (r_state == hcr_pkg::S_DRAIN) && !r_a_vld && !r_b_vld, $stable(r_acc))

endmodule

`default_nettype wire

// ===== verif/hypercube_transition_rate_core_test.sv =====
`timescale 1ns / 100ps

module hypercube_transition_rate_core_test;
    import hcr_pkg::*;

    // Constants of the exponential, held here in the testbench's own terms.
    localparam longint     LOG2E_FIX = 64'h5C55_1D95;
    localparam bit [63:0]  LN2_FIX   = 64'hB172_17F8;
    localparam longint     EXP_CEIL  = 12 * 65536;

    // Run control: phase count and size, the long receiver hold-off, the
    // watchdog limit and the settling time at the end.
    localparam int NUM_PHASES  = 11;
    localparam int PHASE_SLOTS = 110;
    localparam int HOLD_PHASE  = 2;
    localparam int LONG_HOLD   = 700;
    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE      = 200;
    localparam int PRINT_CAP   = 100;

    // Register settings per phase, as raw data on the configuration port.
    // They include the extremes and values that the block must clamp.
    localparam logic [CFG_DATA_W-1:0] PHASE_ORDER [NUM_PHASES] =
        '{4'd4, 4'd2, 4'd3, 4'd0, 4'd7, 4'd12, 4'd2, 4'd3, 4'd4, 4'd1, 4'd4};
    localparam logic [CFG_DATA_W-1:0] PHASE_FEAT [NUM_PHASES] =
        '{4'd8, 4'd1, 4'd5, 4'd3, 4'd8, 4'd0, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8};

    // Weights for the opening checks at order 1 and eight features: zero, the
    // edges of the exponential's range either side of twelve, both extremes
    // of the field and a value just short of saturation.
    localparam int PROBE_W [8] =
        '{0, 786432, 786433, -786432, -786433, 8388607, -8388608, 720896};

    typedef struct {
        logic [OP_W-1:0]         op;
        logic [IDX_W-1:0]        weight_index;
        logic signed [W_W-1:0]   weight_value;
        logic [STATE_W-1:0]      from_state;
        logic [STATE_W-1:0]      to_state;
    } rate_req_t;

    typedef struct {
        logic [RATE_W-1:0]   rate_value;
        logic                not_neighbours;
        logic                saturated;
        logic [STATE_W-1:0]  from_state;
        logic [STATE_W-1:0]  to_state;
    } rate_ans_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    hcr_in_if  req_bus ();
    hcr_out_if rate_bus ();

    hypercube_transition_rate_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (req_bus),
        .o_out       (rate_bus),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // The testbench's own copy of the weight table and of the registers.
    // Entries that were never written stay unknown, and the generator makes
    // sure that no evaluation ever reads one of them.
    logic signed [W_W-1:0]  weights [0:4095];
    bit                     seeded [0:4095];
    logic [ORD_W-1:0]       cfg_order;
    logic [FCW-1:0]         cfg_features;

    rate_req_t  req_backlog [$];
    rate_ans_t  rate_due [$];
    rate_req_t  on_bus;
    rate_ans_t  want;

    int src_idle_pct;
    int snk_idle_pct;
    int src_gap;
    int snk_gap;
    int hold_asked;
    int hold_done;
    int hold_left;
    int quiet;
    int mismatches;
    int n_writes;
    int n_evals;
    int n_neigh;
    int n_sat;
    int n_zero;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Each mismatch costs one line; after a hundred of them only the count
    // goes on, so that a badly broken block cannot flood the log.
    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    function automatic int eff_order();
        int o;
        o = cfg_order;
        if (o < 1) o = 1;
        if (o > 4) o = 4;
        return o;
    endfunction

    function automatic int eff_features();
        int f;
        f = cfg_features;
        if (f < 1) f = 1;
        if (f > MAX_FEATURES_DEF) f = MAX_FEATURES_DEF;
        return f;
    endfunction

    // Feature k sits at bit L-1-k, so feature 0 is the most significant used bit.
    function automatic bit feature_bit(logic [STATE_W-1:0] st, int k, int nf);
        return st[nf - 1 - k];
    endfunction

    // Mostly small weights, so that long sums stay inside the exponential's
    // useful range, with a share of large and fully random values.
    function automatic logic signed [W_W-1:0] draw_weight();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return W_W'(int'($urandom_range(32768)) - 16384);
        if (pick < 85) return W_W'(int'($urandom_range(524288)) - 262144);
        if (pick < 95) return W_W'(int'($urandom_range(1703936)) - 851968);
        return W_W'($urandom);
    endfunction

    function automatic void queue_write(int idx, logic signed [W_W-1:0] val);
        rate_req_t rq;
        rq.op           = OP_WRITE;
        rq.weight_index = IDX_W'(idx);
        rq.weight_value = val;
        rq.from_state   = STATE_W'($urandom);
        rq.to_state     = STATE_W'($urandom);
        seeded[idx]     = 1'b1;
        req_backlog.push_back(rq);
    endfunction

    // One weight term of the sum. When the generator walks the terms in
    // advance it queues a write for every entry not yet written instead.
    function automatic longint weight_term(int addr, bit fill);
        if (fill) begin
            if (!seeded[addr]) queue_write(addr, draw_weight());
            return 0;
        end
        return longint'(weights[addr]);
    endfunction

    // exp(s) in unsigned Q16.16 from a Q.16 sum: base-two split, a Taylor
    // series for the fraction, then a rounding shift.
    function automatic rate_ans_t rate_from_sum(longint s);
        longint     t;
        bit [63:0]  tb;
        bit [63:0]  f;
        bit [63:0]  g;
        bit [63:0]  term;
        bit [63:0]  mant;
        bit [63:0]  r;
        int         k;
        int         n;
        rate_ans_t  ans;
        ans.rate_value     = '0;
        ans.not_neighbours = 1'b0;
        ans.saturated      = 1'b0;
        if (s > EXP_CEIL) begin
            ans.rate_value = '1;
            ans.saturated  = 1'b1;
            return ans;
        end
        if (s < -EXP_CEIL) return ans;
        t    = s * LOG2E_FIX;
        tb   = 64'(t + (64'sd32 <<< 46));
        k    = int'(tb >> 46);
        f    = (tb >> 14) & 64'hFFFF_FFFF;
        g    = (f * LN2_FIX) >> 32;
        term = 64'd1 << 32;
        mant = term;
        for (n = 1; n <= 11; n++) begin
            term = ((term * g) >> 32) / 64'(n);
            mant += term;
        end
        if (k >= 48) begin
            r = mant << (k - 48);
        end else begin
            r = (mant + (64'd1 << (47 - k))) >> (48 - k);
        end
        if (r > 64'hFFFF_FFFF) begin
            ans.rate_value = '1;
            ans.saturated  = 1'b1;
        end else begin
            ans.rate_value = r[31:0];
        end
        return ans;
    endfunction

    // Expected answer to one evaluation under the current registers. With
    // fill set the same walk only queues writes for unwritten entries.
    function automatic rate_ans_t predict_rate(rate_req_t rq, bit fill);
        int                  nf;
        int                  ord;
        int                  locus;
        int                  l;
        int                  m;
        int                  n;
        logic [STATE_W-1:0]  mask;
        logic [STATE_W-1:0]  from;
        logic [STATE_W-1:0]  diff;
        longint              acc;
        rate_ans_t           ans;
        nf   = eff_features();
        ord  = eff_order();
        mask = STATE_W'((1 << nf) - 1);
        from = rq.from_state & mask;
        diff = (rq.to_state & mask) ^ from;
        ans.rate_value     = '0;
        ans.not_neighbours = 1'b1;
        ans.saturated      = 1'b0;
        ans.from_state     = rq.from_state;
        ans.to_state       = rq.to_state;
        if (diff == '0 || (diff & (diff - 1'b1)) != '0) return ans;
        locus = 0;
        while (locus < nf && !feature_bit(diff, locus, nf)) locus++;
        case (ord)
            ORD_SINGLE: begin
                acc = weight_term(locus, fill);
            end
            ORD_PAIR: begin
                acc = weight_term(locus * nf + locus, fill);
                for (l = 0; l < nf; l++) begin
                    if (feature_bit(from, l, nf)) acc += weight_term(l * nf + locus, fill);
                end
            end
            ORD_TRIPLE: begin
                acc = weight_term(locus * (nf * nf + nf + 1), fill);
                for (l = 0; l < nf; l++) begin
                    for (m = l; m < nf; m++) begin
                        if (feature_bit(from, l, nf) && feature_bit(from, m, nf)) begin
                            acc += weight_term(l * nf * nf + m * nf + locus, fill);
                        end
                    end
                end
            end
            default: begin
                acc = weight_term(locus * (nf * nf * nf + nf * nf + nf + 1), fill);
                for (l = 0; l < nf; l++) begin
                    for (m = l; m < nf; m++) begin
                        for (n = m; n < nf; n++) begin
                            if (feature_bit(from, l, nf) && feature_bit(from, m, nf) &&
                                feature_bit(from, n, nf)) begin
                                acc += weight_term(l * nf * nf * nf + m * nf * nf +
                                                   n * nf + locus, fill);
                            end
                        end
                    end
                end
            end
        endcase
        if (fill) return ans;
        ans = rate_from_sum(acc);
        ans.from_state = rq.from_state;
        ans.to_state   = rq.to_state;
        return ans;
    endfunction

    // An evaluation is queued behind the writes that its walk still needs.
    function automatic void queue_eval(logic [STATE_W-1:0] from, logic [STATE_W-1:0] to);
        rate_req_t rq;
        rq.op           = OP_EVAL;
        rq.weight_index = IDX_W'($urandom);
        rq.weight_value = W_W'($urandom);
        rq.from_state   = from;
        rq.to_state     = to;
        void'(predict_rate(rq, 1'b1));
        req_backlog.push_back(rq);
    endfunction

    // Most evaluations are true neighbours with random bits above the used
    // features; the rest are arbitrary pairs, mostly not neighbours.
    function automatic void draw_eval();
        int                  nf;
        int                  locus;
        logic [STATE_W-1:0]  mask;
        logic [STATE_W-1:0]  from;
        logic [STATE_W-1:0]  to;
        nf   = eff_features();
        mask = STATE_W'((1 << nf) - 1);
        from = ($urandom_range(99) < 15) ? '1 : STATE_W'($urandom);
        if ($urandom_range(99) < 80) begin
            locus = $urandom_range(nf - 1);
            to    = from ^ (STATE_W'(1) << (nf - 1 - locus)) ^ (STATE_W'($urandom) & ~mask);
        end else begin
            to = STATE_W'($urandom);
        end
        queue_eval(from, to);
    endfunction

    // Bookkeeping for one accepted transfer on the request side.
    function automatic void take_request(rate_req_t rq);
        rate_ans_t ans;
        if (rq.op == OP_WRITE) begin
            weights[rq.weight_index] = rq.weight_value;
            n_writes++;
        end else begin
            ans = predict_rate(rq, 1'b0);
            rate_due.push_back(ans);
            n_evals++;
            if (!ans.not_neighbours) n_neigh++;
            if (ans.saturated) n_sat++;
            if (!ans.not_neighbours && ans.rate_value == '0) n_zero++;
        end
    endfunction

    // Request driver. A new item is put on the bus only when the slot is free,
    // that is when nothing is offered or the offered item transfers at this
    // edge. Idle bursts are drawn after each item that leaves the queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready) take_request(on_bus);
            if (!req_bus.valid || req_bus.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    req_bus.valid <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    on_bus = req_backlog.pop_front();
                    req_bus.valid        <= 1'b1;
                    req_bus.op           <= on_bus.op;
                    req_bus.weight_index <= on_bus.weight_index;
                    req_bus.weight_value <= on_bus.weight_value;
                    req_bus.from_state   <= on_bus.from_state;
                    req_bus.to_state     <= on_bus.to_state;
                    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
                        src_gap = $urandom_range(1, 14);
                    end
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Every transfer is checked against the oldest expected
    // rate. The ready line is then set for the next edge: a long hold-off when
    // one has been asked for, otherwise random stall bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rate_bus.ready <= 1'b0;
        end else begin
            if (rate_bus.valid && rate_bus.ready) begin
                if (rate_due.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing outstanding",
                                              rate_bus.rate_value));
                end else begin
                    want = rate_due.pop_front();
                    if (rate_bus.rate_value !== want.rate_value) begin
                        report_mismatch($sformatf("rate_value %h, expected %h (%h to %h)",
                                                  rate_bus.rate_value, want.rate_value,
                                                  want.from_state, want.to_state));
                    end
                    if (rate_bus.not_neighbours !== want.not_neighbours) begin
                        report_mismatch($sformatf("not_neighbours %b, expected %b (%h to %h)",
                                                  rate_bus.not_neighbours,
                                                  want.not_neighbours,
                                                  want.from_state, want.to_state));
                    end
                    if (rate_bus.saturated !== want.saturated) begin
                        report_mismatch($sformatf("saturated %b, expected %b (%h to %h)",
                                                  rate_bus.saturated, want.saturated,
                                                  want.from_state, want.to_state));
                    end
                end
            end
            if (hold_done != hold_asked) begin
                hold_done++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                rate_bus.ready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap--;
                rate_bus.ready <= 1'b0;
            end else if (snk_idle_pct != 0 && $urandom_range(99) < snk_idle_pct) begin
                snk_gap = $urandom_range(13);
                rate_bus.ready <= 1'b0;
            end else begin
                rate_bus.ready <= 1'b1;
            end
        end
    end

    // Watchdog: any transfer on either side counts as progress. The limit is
    // well above the long hold-off plus one full order-four evaluation.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_bus.valid && req_bus.ready) ||
            (rate_bus.valid && rate_bus.ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // The block is idle once the queue is empty, nothing is on the bus and
    // every expected rate has been seen. Sampled on the falling edge, where
    // everything driven at the rising edge has settled.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (req_backlog.size() != 0 || req_bus.valid || rate_due.size() != 0);
    endtask

    // Registers are written only while the block is idle. A weight write gives
    // no result, so the task waits a while before the first register write.
    task automatic write_config(input logic [CFG_DATA_W-1:0] ord_data,
                                input logic [CFG_DATA_W-1:0] feat_data);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ORDER;
        i_cfg_data  <= ord_data;
        @(posedge i_clk);
        i_cfg_index <= CFG_FEATURES;
        i_cfg_data  <= feat_data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_order    = ord_data[ORD_W-1:0];
        cfg_features = feat_data;
        @(negedge i_clk);
    endtask

    initial begin
        int ph;
        int slot;
        int i;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_index          = CFG_ORDER;
        i_cfg_data           = '0;
        req_bus.valid        = 1'b0;
        req_bus.op           = OP_WRITE;
        req_bus.weight_index = '0;
        req_bus.weight_value = '0;
        req_bus.from_state   = '0;
        req_bus.to_state     = '0;
        rate_bus.ready       = 1'b0;
        cfg_order            = ORD_RESET;
        cfg_features         = FC_RESET;
        src_idle_pct         = 20;
        snk_idle_pct         = 20;
        src_gap              = 0;
        snk_gap              = 0;
        hold_asked           = 0;
        hold_done            = 0;
        hold_left            = 0;
        quiet                = 0;
        mismatches           = 0;
        n_writes             = 0;
        n_evals              = 0;
        n_neigh              = 0;
        n_sat                = 0;
        n_zero               = 0;
        for (i = 0; i < 4096; i++) seeded[i] = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Opening checks under the reset registers (order one, eight
        // features): the self-weight at each locus covers zero, both sides of
        // the exponential's limits and the extremes of the weight field. Then
        // the highest table index, and pairs that are equal, that differ in
        // two features and that differ in all of them.
        for (i = 0; i < 8; i++) queue_write(i, W_W'(PROBE_W[i]));
        queue_write(4095, 24'h5A5A5A);
        for (i = 0; i < 8; i++) begin
            queue_eval((i % 2) ? 8'hFF : 8'h00,
                       ((i % 2) ? 8'hFF : 8'h00) ^ (8'h80 >> i));
        end
        queue_eval(8'h5A, 8'h5A);
        queue_eval(8'h00, 8'h03);
        queue_eval(8'hFF, 8'h00);
        wait_drained();

        // Random phases, one register setting each. Between phases the
        // sender pauses until every expected rate has come back. The idling
        // pattern changes from phase to phase and the last phase has none.
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            write_config(PHASE_ORDER[ph], PHASE_FEAT[ph]);
            if (ph == NUM_PHASES - 1) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else begin
                case (ph % 3)
                    0:       begin src_idle_pct = 20; snk_idle_pct = 20; end
                    1:       begin src_idle_pct = 0;  snk_idle_pct = 30; end
                    default: begin src_idle_pct = 30; snk_idle_pct = 0;  end
                endcase
            end
            for (slot = 0; slot < PHASE_SLOTS; slot++) begin
                if ($urandom_range(99) < 70) begin
                    draw_eval();
                end else if ($urandom_range(99) < 40) begin
                    queue_write($urandom_range(15), draw_weight());
                end else begin
                    queue_write($urandom_range(4095), draw_weight());
                end
            end
            // Once in the run the receiver stops taking results for a long
            // while, so that the block fills up and stalls its request side.
            if (ph == HOLD_PHASE) hold_asked++;
            wait_drained();
        end

        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        if (rate_due.size() != 0) begin
            report_mismatch($sformatf("%0d expected rates never arrived", rate_due.size()));
        end

        $display("covered %0d weight writes and %0d evaluations over %0d register settings",
                 n_writes, n_evals, NUM_PHASES + 1);
        $display("of the evaluations %0d were neighbours, %0d saturated, %0d rounded to zero",
                 n_neigh, n_sat, n_zero);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule
